[design/rmf5_pkg.sv]
`default_nettype none
package rmf5_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SORT,
    ST_DONE
  } rmf5_state_e;

  // controls from the sequencer to the datapath
  typedef struct packed {
    logic accept;
    logic step;
    logic pass_end;
    logic emit;
  } rmf5_ctrl_t;

endpackage
`default_nettype wire

[design/rmf5_cmpx.sv]
`default_nettype none
module rmf5_cmpx #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic signed [SAMPLE_BITS-1:0] a_i,
  input  wire logic signed [SAMPLE_BITS-1:0] b_i,
  output logic signed [SAMPLE_BITS-1:0]      min_o,
  output logic signed [SAMPLE_BITS-1:0]      max_o
);

  logic a_gt_b;

  assign a_gt_b = a_i > b_i;
  assign min_o  = a_gt_b ? b_i : a_i;
  assign max_o  = a_gt_b ? a_i : b_i;

endmodule
`default_nettype wire

[design/rmf5_seq.sv]
`default_nettype none
module rmf5_seq #(
  parameter int WINDOW = 5
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           sample_valid_i,
  input  wire logic           out_free_i,
  output logic                sample_stall_o,
  output rmf5_pkg::rmf5_ctrl_t ctrl_o
);
  import rmf5_pkg::*;

  localparam int Passes = WINDOW - WINDOW / 2;
  localparam int StepW  = $clog2(WINDOW);
  localparam int PassW  = $clog2(Passes);

  rmf5_state_e      state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [PassW-1:0] pass_q, pass_d;
  logic             last_step;
  logic             last_pass;

  assign last_step = step_q == StepW'(WINDOW - 1);
  assign last_pass = pass_q == PassW'(Passes - 1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (sample_valid_i) state_d = ST_SORT;
      end
      ST_SORT: begin
        if (last_step && last_pass) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl_o         = '0;
    sample_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        sample_stall_o = 1'b0;
        ctrl_o.accept  = sample_valid_i;
      end
      ST_SORT: begin
        ctrl_o.step     = 1'b1;
        ctrl_o.pass_end = last_step && !last_pass;
      end
      ST_DONE: begin
        ctrl_o.emit = out_free_i;
      end
      default: begin
        sample_stall_o = 1'b1;
      end
    endcase
  end

  // step and pass counters
  always_comb begin
    step_d = step_q;
    pass_d = pass_q;
    if (ctrl_o.accept) begin
      step_d = '0;
      pass_d = '0;
    end else if (ctrl_o.step) begin
      step_d = last_step ? '0 : step_q + StepW'(1);
      if (last_step) pass_d = pass_q + PassW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      pass_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      pass_q  <= pass_d;
    end
  end

endmodule
`default_nettype wire

[design/running_median_of_five_core.sv]
`default_nettype none
// Running median filter over the last WINDOW signed samples.
// Input channel: sample_i with sample_valid_i / sample_stall_o. A beat is
// taken when valid is high and stall is low; it enters the window and the
// oldest sample drops out.
// Output channel: median_o with median_valid_o / median_stall_i, one beat
// for every input beat, in order.
// The median is found by one shared compare-exchange unit stepping over a
// rotating copy of the window: each pass over all WINDOW entries pulls out the
// largest value left, and WINDOW - WINDOW/2 passes leave the median.
// The input is stalled for the whole sort and until its result is stored, so
// a new beat is only taken once the last one is through; the result sits in an
// output register while the next beat is taken, and the sort only waits if that
// register is still full at its end.
// Reset clears the window to zeros, so the first results count those zeros
// as samples, and empties the output register.
// A stalled output beat holds its value until it is taken.
module running_median_of_five_core #(
  parameter int WINDOW      = 5,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          sample_valid_i,
  output logic                               sample_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                               median_valid_o,
  input  wire logic                          median_stall_i,
  output logic signed [SAMPLE_BITS-1:0]      median_o
);
  import rmf5_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] Lowest = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  rmf5_ctrl_t ctrl;
  logic       out_free;

  logic signed [SAMPLE_BITS-1:0] window_q [WINDOW];
  logic signed [SAMPLE_BITS-1:0] window_d [WINDOW];
  logic signed [SAMPLE_BITS-1:0] ring_q   [WINDOW];
  logic signed [SAMPLE_BITS-1:0] ring_d   [WINDOW];
  logic signed [SAMPLE_BITS-1:0] hi_q, hi_d;
  logic signed [SAMPLE_BITS-1:0] cmp_min, cmp_max;
  logic signed [SAMPLE_BITS-1:0] median_q;
  logic                          median_valid_q, median_valid_d;

  assign out_free = !median_valid_q || !median_stall_i;

  rmf5_seq #(
    .WINDOW(WINDOW)
  ) u_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .sample_valid_i (sample_valid_i),
    .out_free_i     (out_free),
    .sample_stall_o (sample_stall_o),
    .ctrl_o         (ctrl)
  );

  rmf5_cmpx #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_cmpx (
    .a_i   (hi_q),
    .b_i   (ring_q[0]),
    .min_o (cmp_min),
    .max_o (cmp_max)
  );

  // window shift
  always_comb begin
    window_d = window_q;
    if (ctrl.accept) begin
      window_d[0] = sample_i;
      for (int i = 1; i < WINDOW; i++) window_d[i] = window_q[i-1];
    end
  end

  // rotating sort copy, smaller value goes back to the tail
  // the largest left is dropped at the end of every pass but the last
  always_comb begin
    ring_d = ring_q;
    hi_d   = hi_q;
    if (ctrl.accept) begin
      ring_d = window_d;
      hi_d   = Lowest;
    end else if (ctrl.step) begin
      for (int i = 0; i < WINDOW - 1; i++) ring_d[i] = ring_q[i+1];
      ring_d[WINDOW-1] = cmp_min;
      hi_d             = ctrl.pass_end ? Lowest : cmp_max;
    end
  end

  assign median_valid_d = ctrl.emit || (median_valid_q && median_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) window_q[i] <= '0;
      median_valid_q <= 1'b0;
    end else begin
      window_q       <= window_d;
      median_valid_q <= median_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ring_q <= ring_d;
    hi_q   <= hi_d;
    if (ctrl.emit) median_q <= hi_q;
  end

  assign median_valid_o = median_valid_q;
  assign median_o       = median_q;

endmodule
`default_nettype wire

[bench/tb_running_median_of_five_core.sv]
`timescale 1ns / 100ps
module tb_running_median_of_five_core;

  localparam int WINDOW_LEN = 5;
  localparam int SAMPLE_W   = 16;
  localparam int MID        = WINDOW_LEN / 2;
  localparam int LATENCY    = WINDOW_LEN * (WINDOW_LEN - MID) + 2;
  localparam int HOLD_OFF   = 400;
  localparam int CYCLE_CAP  = 1_000_000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  logic    clk_i;
  logic    rst_ni;
  logic    sample_valid_i;
  logic    sample_stall_o;
  sample_t sample_i;
  logic    median_valid_o;
  logic    median_stall_i;
  sample_t median_o;

  sample_t history [WINDOW_LEN];
  sample_t expected_medians [$];
  sample_t oldest_median;
  sample_t last_sent;
  int      mismatches;
  int      cycles;
  bit      hold_off_req;
  int      hold_left;
  int      stall_pct;
  int      pattern_left;

  running_median_of_five_core #(
    .WINDOW     (WINDOW_LEN),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sample_valid_i(sample_valid_i),
    .sample_stall_o(sample_stall_o),
    .sample_i      (sample_i),
    .median_valid_o(median_valid_o),
    .median_stall_i(median_stall_i),
    .median_o      (median_o)
  );

  always #5 clk_i = ~clk_i;

  // shift the new sample in and return the middle of the sorted history
  function automatic sample_t push_and_median(input sample_t s);
    sample_t sorted [WINDOW_LEN];
    sample_t t;
    for (int i = WINDOW_LEN - 1; i > 0; i--) history[i] = history[i-1];
    history[0] = s;
    sorted = history;
    for (int i = 0; i < WINDOW_LEN - 1; i++) begin
      for (int j = 0; j < WINDOW_LEN - 1 - i; j++) begin
        if (sorted[j] > sorted[j+1]) begin
          t           = sorted[j];
          sorted[j]   = sorted[j+1];
          sorted[j+1] = t;
        end
      end
    end
    return sorted[MID];
  endfunction

  // valid stays high after the beat; a gap or the next beat changes it
  task automatic send_sample(input sample_t s);
    @(negedge clk_i);
    sample_valid_i <= 1'b1;
    sample_i       <= s;
    do @(posedge clk_i); while (sample_stall_o !== 1'b0);
    expected_medians.push_back(push_and_median(s));
    last_sent = s;
  endtask

  task automatic idle_for(input int n);
    if (n > 0) begin
      @(negedge clk_i);
      sample_valid_i <= 1'b0;
      sample_i       <= sample_t'($urandom);
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_for_all_medians();
    while (expected_medians.size() != 0) @(posedge clk_i);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(5))
      0:       return sample_t'($urandom);
      1:       return sample_t'($urandom_range(8)) - sample_t'(4);
      2:       return sample_t'(32767 - $urandom_range(15));
      3:       return sample_t'(-32768 + $urandom_range(15));
      4:       return last_sent + sample_t'($urandom_range(128)) - sample_t'(64);
      default: return history[$urandom_range(WINDOW_LEN - 1)];
    endcase
  endfunction

  task automatic send_bursts(input int count);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++) begin
        send_sample(random_sample());
        sent++;
      end
      if ($urandom_range(2) != 0) idle_for($urandom_range(1, 20));
    end
  endtask

  // warm-up zeros, extremes, ties and sign changes, back to back
  task automatic test_warmup_and_extremes();
    sample_t seq [22] = '{
      100, -100, 200, -200, 7,
      32767, 32767, 32767,
      -32768, -32768, -32768,
      -1, 1, -1, 0, 32767, -32768,
      5, 5, 5, -5, -5
    };
    foreach (seq[i]) send_sample(seq[i]);
    idle_for(1);
  endtask

  task automatic test_random_samples();
    send_bursts(1000);
  endtask

  // receiver holds off while beats keep coming, so the input stalls
  task automatic test_output_hold_off();
    hold_off_req = 1'b1;
    repeat (12) send_sample(random_sample());
    idle_for(1);
  endtask

  // sender pauses until everything has drained, then carries on
  task automatic test_drain_pause();
    send_bursts(400);
    idle_for(1);
    wait_for_all_medians();
    send_bursts(600);
    idle_for(1);
  endtask

  always @(negedge clk_i) begin
    if (hold_off_req) begin
      hold_left    = HOLD_OFF;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      median_stall_i <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(3))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          2:       stall_pct = 50;
          default: stall_pct = 90;
        endcase
        pattern_left = $urandom_range(20, 200);
      end
      pattern_left--;
      median_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && median_valid_o === 1'b1 && median_stall_i === 1'b0) begin
      if (expected_medians.size() == 0) begin
        $error("median: unexpected beat, got %0d", median_o);
        mismatches++;
      end else begin
        oldest_median = expected_medians.pop_front();
        if (median_o !== oldest_median) begin
          $error("median: expected %0d, got %0d", oldest_median, median_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_CAP) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    sample_valid_i = 1'b0;
    sample_i       = '0;
    median_stall_i = 1'b0;
    mismatches     = 0;
    cycles         = 0;
    hold_off_req   = 1'b0;
    hold_left      = 0;
    stall_pct      = 0;
    pattern_left   = 0;
    last_sent      = '0;
    foreach (history[i]) history[i] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_warmup_and_extremes();
    test_random_samples();
    test_output_hold_off();
    test_drain_pause();

    wait_for_all_medians();
    repeat (2 * LATENCY) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
